@@ sv/double_hash_table_lookup_insert_top_macros.svh @@
// assertion macros for the hash table block
`ifndef DOUBLE_HASH_TABLE_LOOKUP_INSERT_TOP_MACROS_SVH
`define DOUBLE_HASH_TABLE_LOOKUP_INSERT_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define DHT_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define DHT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/dhtl_pkg.sv @@
// shared constants and types of the hash table block
package dhtl_pkg;

	localparam int SLOTS_DEF      = 1024;
	localparam int KEY_BYTES_DEF  = 8;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int HASH_W    = 32;
	localparam int MOD_DIGIT = 4;
	localparam int TS_W      = 10;
	localparam int SLOT_W    = 10;
	localparam int LEN_W     = 4;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;

	localparam logic [TS_W-1:0] TS_RESET = 10'd521;
	localparam logic            REG_TABLE_SIZE = 1'b0;

	typedef enum logic [1:0] {
		STS_FOUND     = 2'd0,
		STS_INSERTED  = 2'd1,
		STS_NOT_FOUND = 2'd2,
		STS_FULL      = 2'd3
	} status_t;

endpackage

@@ sv/dhtl_ram.sv @@
// generic single-write, single-read ram with registered read data
module dhtl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ sv/dhtl_mod.sv @@
// iterative remainder unit, MOD_DIGIT dividend bits per step
module dhtl_mod #(
	parameter int IDX_W = 10
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [dhtl_pkg::HASH_W-1:0] dividend,
	input  logic [IDX_W-1:0]          divisor,
	output logic                      done,
	output logic [IDX_W-1:0]          rem
);
	import dhtl_pkg::*;

	localparam int STEPS = HASH_W / MOD_DIGIT;
	localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [HASH_W-1:0] dvd_q;
	logic [IDX_W-1:0]  div_q;
	logic [IDX_W-1:0]  rem_q;
	logic [IDX_W-1:0]  rem_nx;

	// restoring remainder over one digit
	always_comb begin
		logic [IDX_W:0]   t;
		logic [IDX_W-1:0] r;
		r = rem_q;
		for (int k = 0; k < MOD_DIGIT; k++) begin
			t = {r, dvd_q[HASH_W-1-k]};
			if (t >= {1'b0, div_q}) begin
				t = t - {1'b0, div_q};
			end
			r = t[IDX_W-1:0];
		end
		rem_nx = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << MOD_DIGIT;
			rem_q <= rem_nx;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

@@ sv/double_hash_table_lookup_insert_top.sv @@
// hash table with open addressing and double hashing, find or enter
// per item: hash over the key_len key bytes, two remainders, then a read and
//   a compare per probe; one item at a time, set by the probe loop
//   through the single read port of the slot ram and the shared remainder unit
// reset: table_size returns to 521, then a clearing pass over all SLOTS slots
//   empties every slot while no item is taken (configuration still accepted)
`include "double_hash_table_lookup_insert_top_macros.svh"

module double_hash_table_lookup_insert_top #(
	parameter int SLOTS      = dhtl_pkg::SLOTS_DEF,
	parameter int KEY_BYTES  = dhtl_pkg::KEY_BYTES_DEF,
	parameter int DATA_WIDTH = dhtl_pkg::DATA_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [dhtl_pkg::PADDR_W-1:0] paddr,
	input  logic [dhtl_pkg::PDATA_W-1:0] pwdata,
	output logic [dhtl_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         mode,
	input  logic [63:0]                  key_bytes,
	input  logic [3:0]                   key_len,
	input  logic [31:0]                  data_in,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [1:0]                   status,
	output logic [31:0]                  data_out,
	output logic [9:0]                   slot
);
	import dhtl_pkg::*;

	localparam int IDX_W  = $clog2(SLOTS);
	localparam int KW     = 8 * KEY_BYTES;
	localparam int DSW    = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
	localparam int EW     = HASH_W + LEN_W + KW + DSW;
	localparam int SZ_MAX = SLOTS - 1;

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_HASH  = 7'b0000100,
		S_MOD1  = 7'b0001000,
		S_MOD2  = 7'b0010000,
		S_RD    = 7'b0100000,
		S_CMP   = 7'b1000000
	} state_t;

	typedef struct packed {
		logic [HASH_W-1:0] hash;
		logic [LEN_W-1:0]  len;
		logic [KW-1:0]     key;
		logic [DSW-1:0]    data;
	} entry_t;

	state_t            state_q;
	logic [TS_W-1:0]   ts_q;
	logic [IDX_W-1:0]  clr_q;
	logic [IDX_W:0]    fill_q;

	logic              mode_q;
	logic [KW-1:0]     key_q;
	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  cnt_q;
	logic [DSW-1:0]    din_q;
	logic [HASH_W-1:0] hash_q;
	logic [IDX_W-1:0]  sz_q;
	logic [IDX_W-1:0]  first_q;
	logic [IDX_W-1:0]  step_q;
	logic [IDX_W-1:0]  idx_q;

	logic              pend_q;
	status_t           res_sts_q;
	logic [31:0]       res_data_q;
	logic [IDX_W-1:0]  res_idx_q;

	logic              out_valid_q;
	status_t           out_sts_q;
	logic [31:0]       out_data_q;
	logic [SLOT_W-1:0] out_slot_q;

	logic              in_acc;
	logic              cfg_we;
	logic [LEN_W-1:0]  len_c;
	logic [KW-1:0]     key_c;
	logic [IDX_W-1:0]  sz_c;
	logic [HASH_W-1:0] hash_fix;

	logic              mod_start;
	logic [HASH_W-1:0] mod_dvd;
	logic [IDX_W-1:0]  mod_div;
	logic              mod_done;
	logic [IDX_W-1:0]  mod_rem;

	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	entry_t            ram_wdata;
	entry_t            ent;
	logic [EW-1:0]     ram_rdata;

	logic              ent_empty;
	logic              ent_hit;
	logic              ins;
	logic [IDX_W-1:0]  idx_nx;
	logic              out_free;

	// configuration port
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_TABLE_SIZE);
	assign prdata = (paddr[2] == REG_TABLE_SIZE) ? PDATA_W'(ts_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_q <= TS_RESET;
		end else if (cfg_we) begin
			ts_q <= pwdata[TS_W-1:0];
		end
	end

	// request capture
	assign in_stall = (state_q != S_IDLE) || pend_q;
	assign in_acc   = in_valid && !in_stall;

	always_comb begin
		len_c = (key_len > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES) : key_len;
		for (int b = 0; b < KEY_BYTES; b++) begin
			key_c[8*b +: 8] = (LEN_W'(b) < len_c) ? key_bytes[8*b +: 8] : 8'd0;
		end
		if (ts_q < TS_W'(3)) begin
			sz_c = IDX_W'(3);
		end else if (int'(ts_q) > SZ_MAX) begin
			sz_c = IDX_W'(SZ_MAX);
		end else begin
			sz_c = IDX_W'(ts_q);
		end
		hash_fix = (hash_q == '0) ? HASH_W'(1) : hash_q;
	end

	// shared remainder unit
	always_comb begin
		mod_start = 1'b0;
		mod_dvd   = hash_fix;
		mod_div   = sz_q;
		if (state_q == S_HASH && cnt_q == '0) begin
			mod_start = 1'b1;
		end else if (state_q == S_MOD1 && mod_done) begin
			mod_start = 1'b1;
			mod_div   = sz_q - IDX_W'(2);
		end
	end

	dhtl_mod #(
		.IDX_W(IDX_W)
	) u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mod_start),
		.dividend(mod_dvd),
		.divisor (mod_div),
		.done    (mod_done),
		.rem     (mod_rem)
	);

	// slot store
	assign ent       = entry_t'(ram_rdata);
	assign ent_empty = (ent.hash == '0);
	assign ent_hit   = !ent_empty && (ent.hash == hash_q) && (ent.len == len_q)
		&& (ent.key == key_q);
	assign ins       = (state_q == S_CMP) && !ent_hit && ent_empty && mode_q
		&& (fill_q < {1'b0, sz_q});

	// backward step with wrap over slots 1..size
	always_comb begin
		logic [IDX_W:0] wrap;
		wrap = {1'b0, sz_q} + {1'b0, idx_q} - {1'b0, step_q};
		if (idx_q <= step_q) begin
			idx_nx = wrap[IDX_W-1:0];
		end else begin
			idx_nx = idx_q - step_q;
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = '{hash: hash_q, len: len_q, key: key_q, data: din_q};
		if (state_q == S_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if (ins) begin
			ram_we = 1'b1;
		end
	end

	dhtl_ram #(
		.WIDTH(EW),
		.DEPTH(SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			fill_q  <= '0;
			pend_q  <= 1'b0;
		end else begin
			if (pend_q && out_free) begin
				pend_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IDX_W'(SLOTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					if (cnt_q == '0) begin
						state_q <= S_MOD1;
					end
				end
				S_MOD1: begin
					if (mod_done) begin
						state_q <= S_MOD2;
					end
				end
				S_MOD2: begin
					if (mod_done) begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (ent_hit || ent_empty || idx_nx == first_q) begin
						state_q <= S_IDLE;
						pend_q  <= 1'b1;
					end else begin
						state_q <= S_RD;
					end
					if (ins) begin
						fill_q <= fill_q + 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_q <= mode;
			key_q  <= key_c;
			len_q  <= len_c;
			cnt_q  <= len_c;
			din_q  <= data_in[DSW-1:0];
			hash_q <= HASH_W'(len_c);
			sz_q   <= sz_c;
		end
		if (state_q == S_HASH) begin
			if (cnt_q != '0) begin
				hash_q <= (hash_q << 4) + HASH_W'(key_q[8*(cnt_q - 1'b1) +: 8]);
				cnt_q  <= cnt_q - 1'b1;
			end else begin
				hash_q <= hash_fix;
			end
		end
		if (state_q == S_MOD1 && mod_done) begin
			first_q <= mod_rem + 1'b1;
		end
		if (state_q == S_MOD2 && mod_done) begin
			step_q <= mod_rem + 1'b1;
			idx_q  <= first_q;
		end
		if (state_q == S_CMP) begin
			if (ent_hit) begin
				res_sts_q  <= STS_FOUND;
				res_data_q <= 32'(ent.data);
				res_idx_q  <= idx_q;
			end else if (ins) begin
				res_sts_q  <= STS_INSERTED;
				res_data_q <= 32'(din_q);
				res_idx_q  <= idx_q;
			end else begin
				idx_q      <= idx_nx;
				res_data_q <= '0;
				res_idx_q  <= '0;
				if (mode_q) begin
					res_sts_q <= STS_FULL;
				end else begin
					res_sts_q <= STS_NOT_FOUND;
				end
			end
		end
	end

	// output register
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= pend_q;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_q && out_free) begin
			out_sts_q  <= res_sts_q;
			out_data_q <= res_data_q;
			out_slot_q <= SLOT_W'(res_idx_q);
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_sts_q;
	assign data_out  = out_data_q;
	assign slot      = out_slot_q;

	`DHT_ASSERT_IMPL(a_probe_range, state_q == S_RD,
		(idx_q != '0) && (idx_q <= sz_q), "probe index outside the table")
	`DHT_ASSERT_IMPL(a_step_range, state_q == S_RD,
		(step_q != '0) && (step_q < sz_q), "probe step outside its range")
	`DHT_ASSERT_NEXT(a_fill_inc, ins, fill_q == $past(fill_q) + 1'b1,
		"fill count not advanced on insert")

endmodule
